/* sv/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants of the text terminal character engine.
// ----------------------------------------------------------------------------
package tte_pkg;

   typedef enum logic [1:0] {
      REQ_PROT  = 2'd0,
      REQ_KEY   = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_READ  = 2'd3
   } tte_req_kind_type;

   localparam logic [7:0]  CH_NULL      = 8'd0;
   localparam logic [7:0]  CH_BELL      = 8'd7;
   localparam logic [7:0]  CH_BACKSPACE = 8'd8;
   localparam logic [7:0]  CH_TAB       = 8'd9;
   localparam logic [7:0]  CH_NEWLINE   = 8'd10;
   localparam logic [7:0]  CH_SPACE     = 8'h20;
   localparam logic [7:0]  COLOR_RESET  = 8'h0F;
   localparam logic [15:0] CELL_RESET   = 16'h0F20;

   typedef struct packed {
      tte_req_kind_type req_type;
      logic [7:0]       char_code;
      logic [10:0]      cell_addr;
   } tte_request_type;

   typedef struct packed {
      logic [10:0] cursor_index;
      logic        bell;
      logic        scrolled;
      logic [15:0] read_data;
   } tte_result_type;

   // write port control: use_rd takes the data from the last read
   typedef struct packed {
      logic en;
      logic use_rd;
   } tte_wr_ctl_type;

endpackage

/* sv/tte_req_if.sv */
// ----------------------------------------------------------------------------
// tte_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface tte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  char_code;
   logic [10:0] cell_addr;

   modport source (output valid, output req_type, output char_code, output cell_addr,
                   input ready);
   modport sink   (input valid, input req_type, input char_code, input cell_addr,
                   output ready);
endinterface

/* sv/tte_rsp_if.sv */
// ----------------------------------------------------------------------------
// tte_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface tte_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cursor_index;
   logic        bell;
   logic        scrolled;
   logic [15:0] read_data;

   modport source (output valid, output cursor_index, output bell, output scrolled,
                   output read_data, input ready);
   modport sink   (input valid, input cursor_index, input bell, input scrolled,
                   input read_data, output ready);
endinterface

/* sv/tte_screen_mem.sv */
// ----------------------------------------------------------------------------
// tte_screen_mem
// Screen cell store: one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module tte_screen_mem #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                    clock,
   input  tte_pkg::tte_wr_ctl_type wr_ctl,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  logic [15:0]             wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output logic [15:0]             rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;
   logic [15:0] wr_word;

   // copy writes (scroll) reuse the word read in the previous cycle
   assign wr_word = wr_ctl.use_rd ? rd_data_ff : wr_data;
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.en) begin
         mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         if (wr_ctl.en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_word;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

endmodule

/* sv/tte_ctrl.sv */
// ----------------------------------------------------------------------------
// tte_ctrl
// Request sequencer: cursor, protect marks, cell writes and reads, scroll and fill sweeps.
// ----------------------------------------------------------------------------
module tte_ctrl #(
   parameter int COLUMNS  = 80,
   parameter int LAST_ROW = 24,
   parameter int TAB_STEP = 4,
   localparam int ROWS    = LAST_ROW + 1,
   localparam int CELLS   = ROWS * COLUMNS,
   localparam int ADDR_W  = $clog2(CELLS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tte_pkg::tte_request_type req,
   input  logic [7:0]               text_color,
   output logic                     res_valid,
   input  logic                     res_take,
   output tte_pkg::tte_result_type  res,
   output tte_pkg::tte_wr_ctl_type  wr_ctl,
   output logic [ADDR_W-1:0]        wr_addr,
   output logic [15:0]              wr_data,
   output logic                     rd_en,
   output logic [ADDR_W-1:0]        rd_addr,
   input  logic [15:0]              rd_data
);

   localparam int ROW_W   = $clog2(LAST_ROW + 2);
   localparam int MROW_W  = $clog2(ROWS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int MARK_W  = $clog2(COLUMNS + 1);
   localparam int SUM_W   = $clog2(COLUMNS + TAB_STEP + 1);
   localparam int TCNT_W  = $clog2(TAB_STEP + 1);
   localparam int IDX_RAW = $clog2(CELLS + COLUMNS);
   localparam int IDX_W   = (IDX_RAW > 11) ? IDX_RAW : 11;
   localparam int COPY_N  = LAST_ROW * COLUMNS;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_EXEC, ST_READ, ST_TAB, ST_CHECK, ST_SCROLL, ST_FILL, ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [MARK_W-1:0]          mark_ff [ROWS];
   logic [MARK_W-1:0]          mark_in [ROWS];
   logic [ADDR_W-1:0]          cnt_ff, cnt_in;
   logic [TCNT_W-1:0]          tcnt_ff, tcnt_in;
   tte_pkg::tte_wr_ctl_type    pw_ctl_ff, pw_ctl_in;
   logic [ADDR_W-1:0]          pw_addr_ff, pw_addr_in;
   logic [15:0]                pw_data_ff, pw_data_in;
   tte_pkg::tte_req_kind_type  kind_ff, kind_in;
   logic [7:0]                 char_ff, char_in;
   logic [10:0]                addr_ff, addr_in;
   logic                       bell_ff, bell_in;
   logic                       scr_ff, scr_in;
   logic [15:0]                rdata_ff, rdata_in;
   logic [15:0]                fill_ff, fill_in;

   function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_index = IDX_W'(r) * IDX_W'(COLUMNS) + IDX_W'(c);
   endfunction

   function automatic logic [MARK_W-1:0] mark_sat(input logic [MARK_W-1:0] m,
                                                  input logic [SUM_W-1:0] amt);
      logic [SUM_W-1:0] s;
      s = SUM_W'(m) + amt;
      if (s > SUM_W'(COLUMNS)) begin
         mark_sat = MARK_W'(COLUMNS);
      end else begin
         mark_sat = MARK_W'(s);
      end
   endfunction

   always_comb begin
      logic             prot;
      logic [ROW_W-1:0] nrow;
      logic [ROW_W-1:0] prow;
      logic [SUM_W-1:0] tcol;
      logic [SUM_W-1:0] acol;

      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      mark_in    = mark_ff;
      cnt_in     = cnt_ff;
      tcnt_in    = tcnt_ff;
      pw_ctl_in  = '0;
      pw_addr_in = pw_addr_ff;
      pw_data_in = pw_data_ff;
      kind_in    = kind_ff;
      char_in    = char_ff;
      addr_in    = addr_ff;
      bell_in    = bell_ff;
      scr_in     = scr_ff;
      rdata_in   = rdata_ff;
      fill_in    = fill_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;

      prot = (kind_ff == tte_pkg::REQ_PROT);
      nrow = row_ff;
      prow = row_ff - ROW_W'(1);
      tcol = SUM_W'(col_ff) + SUM_W'(tcnt_ff);
      acol = SUM_W'(col_ff) + SUM_W'(TAB_STEP);

      unique case (state_ff)
         ST_INIT: begin
            pw_ctl_in.en = 1'b1;
            pw_addr_in   = cnt_ff;
            pw_data_in   = tte_pkg::CELL_RESET;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req.req_type;
               char_in  = req.char_code;
               addr_in  = req.cell_addr;
               bell_in  = 1'b0;
               scr_in   = 1'b0;
               rdata_in = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (kind_ff)
               tte_pkg::REQ_CLEAR: begin
                  fill_in = {text_color, tte_pkg::CH_SPACE};
                  cnt_in  = '0;
                  row_in  = '0;
                  col_in  = '0;
                  for (int i = 0; i < ROWS; i++) begin
                     mark_in[i] = '0;
                  end
                  state_in = ST_FILL;
               end
               tte_pkg::REQ_READ: begin
                  if (IDX_W'(addr_ff) < IDX_W'(CELLS)) begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(addr_ff);
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  // keyboard backspace may not cross the row's mark
                  if (!prot && (char_ff == tte_pkg::CH_BACKSPACE) &&
                      !(SUM_W'(col_ff) > SUM_W'(mark_ff[row_ff[MROW_W-1:0]]))) begin
                     state_in = ST_DONE;
                  end else begin
                     unique case (char_ff)
                        tte_pkg::CH_NEWLINE: begin
                           col_in   = '0;
                           row_in   = row_ff + ROW_W'(1);
                           state_in = ST_CHECK;
                        end
                        tte_pkg::CH_BACKSPACE: begin
                           if (col_ff != '0) begin
                              col_in           = col_ff - COL_W'(1);
                              pw_ctl_in.en     = 1'b1;
                              pw_addr_in       = ADDR_W'(cell_index(row_ff, col_ff - COL_W'(1)));
                              pw_data_in       = {text_color, tte_pkg::CH_SPACE};
                           end else if (row_ff != '0) begin
                              row_in = prow;
                              if (SUM_W'(mark_ff[prow[MROW_W-1:0]]) > SUM_W'(COLUMNS - 1)) begin
                                 col_in = COL_W'(COLUMNS - 1);
                              end else begin
                                 col_in = COL_W'(mark_ff[prow[MROW_W-1:0]]);
                              end
                           end
                           state_in = ST_CHECK;
                        end
                        tte_pkg::CH_BELL: begin
                           bell_in  = 1'b1;
                           state_in = ST_DONE;
                        end
                        tte_pkg::CH_TAB: begin
                           if (acol >= SUM_W'(COLUMNS)) begin
                              col_in = '0;
                              row_in = row_ff + ROW_W'(1);
                           end
                           tcnt_in  = '0;
                           state_in = ST_TAB;
                        end
                        tte_pkg::CH_NULL: begin
                           state_in = ST_DONE;
                        end
                        default: begin
                           pw_ctl_in.en = 1'b1;
                           pw_addr_in   = ADDR_W'(cell_index(row_ff, col_ff));
                           pw_data_in   = {text_color, char_ff};
                           if (col_ff == COL_W'(COLUMNS - 1)) begin
                              col_in = '0;
                              nrow   = row_ff + ROW_W'(1);
                           end else begin
                              col_in = col_ff + COL_W'(1);
                           end
                           row_in = nrow;
                           if (prot && (nrow <= ROW_W'(LAST_ROW))) begin
                              mark_in[nrow[MROW_W-1:0]] =
                                 mark_sat(mark_ff[nrow[MROW_W-1:0]], SUM_W'(1));
                           end
                           state_in = ST_CHECK;
                        end
                     endcase
                  end
               end
            endcase
         end
         ST_READ: begin
            rdata_in = rd_data;
            state_in = ST_DONE;
         end
         ST_TAB: begin
            // one blank cell per cycle; cells past the row end or screen are dropped
            if ((row_ff <= ROW_W'(LAST_ROW)) && (tcol < SUM_W'(COLUMNS))) begin
               pw_ctl_in.en = 1'b1;
               pw_addr_in   = ADDR_W'(cell_index(row_ff, COL_W'(tcol)));
               pw_data_in   = {text_color, tte_pkg::CH_SPACE};
            end
            if (tcnt_ff == TCNT_W'(TAB_STEP - 1)) begin
               if (acol > SUM_W'(COLUMNS - 1)) begin
                  col_in = COL_W'(COLUMNS - 1);
               end else begin
                  col_in = COL_W'(acol);
               end
               if (prot && (row_ff <= ROW_W'(LAST_ROW))) begin
                  mark_in[row_ff[MROW_W-1:0]] =
                     mark_sat(mark_ff[row_ff[MROW_W-1:0]], SUM_W'(TAB_STEP));
               end
               state_in = ST_CHECK;
            end else begin
               tcnt_in = tcnt_ff + TCNT_W'(1);
            end
         end
         ST_CHECK: begin
            if (row_ff > ROW_W'(LAST_ROW)) begin
               for (int i = 0; i < LAST_ROW; i++) begin
                  mark_in[i] = mark_ff[i + 1];
               end
               mark_in[LAST_ROW] = '0;
               row_in   = ROW_W'(LAST_ROW);
               scr_in   = 1'b1;
               cnt_in   = '0;
               state_in = ST_SCROLL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL: begin
            // read one row below, write it back in the next cycle; last row gets blanks
            pw_ctl_in.en = 1'b1;
            pw_addr_in   = cnt_ff;
            if (cnt_ff < ADDR_W'(COPY_N)) begin
               pw_ctl_in.use_rd = 1'b1;
               rd_en            = 1'b1;
               rd_addr          = cnt_ff + ADDR_W'(COLUMNS);
            end else begin
               pw_data_in = {text_color, tte_pkg::CH_SPACE};
            end
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_FILL: begin
            pw_ctl_in.en = 1'b1;
            pw_addr_in   = cnt_ff;
            pw_data_in   = fill_ff;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tcnt_ff    <= tcnt_in;
      pw_addr_ff <= pw_addr_in;
      pw_data_ff <= pw_data_in;
      kind_ff    <= kind_in;
      char_ff    <= char_in;
      addr_ff    <= addr_in;
      bell_ff    <= bell_in;
      scr_ff     <= scr_in;
      rdata_ff   <= rdata_in;
      fill_ff    <= fill_in;
      if (reset) begin
         state_ff  <= ST_INIT;
         row_ff    <= '0;
         col_ff    <= '0;
         pw_ctl_ff <= '0;
         cnt_ff    <= '0;
         for (int i = 0; i < ROWS; i++) begin
            mark_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         pw_ctl_ff <= pw_ctl_in;
         cnt_ff    <= cnt_in;
         mark_ff   <= mark_in;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign res_valid        = (state_ff == ST_DONE);
   assign res.cursor_index = 11'(cell_index(row_ff, col_ff));
   assign res.bell         = bell_ff;
   assign res.scrolled     = scr_ff;
   assign res.read_data    = rdata_ff;
   assign wr_ctl           = pw_ctl_ff;
   assign wr_addr          = pw_addr_ff;
   assign wr_data          = pw_data_ff;

   // a scroll always brings the cursor back onto the screen before the result
   a_row_on_screen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (row_ff <= ROW_W'(LAST_ROW)))
      else $error("cursor row beyond last row at result");

   // a copy write takes its word from a read issued the cycle before
   a_copy_after_read: assert property (@(posedge clock) disable iff (reset)
      pw_ctl_ff.use_rd |-> $past(rd_en))
      else $error("copy write without preceding read");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (SUM_W'(col_ff) <= SUM_W'(COLUMNS - 1)))
      else $error("cursor column past row end");

   a_mark_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         (SUM_W'(mark_ff[row_ff[MROW_W-1:0]]) <= SUM_W'(COLUMNS)))
      else $error("protect mark above saturation");

   a_scroll_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> scr_ff)
      else $error("scroll sweep without scrolled flag");

endmodule

/* sv/text_terminal_char_engine_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_char_engine_unit
// Text terminal engine: screen store, cursor, protect marks, scroll and clear.
// ----------------------------------------------------------------------------
// After reset the screen store is blanked by a sweep over all of its
// (LAST_ROW+1)*COLUMNS cells (2000 by default) during which no request word
// is taken; colour writes on csr_we are accepted throughout. Each request
// takes one word on req_port and returns one word on rsp_port. Timing is set
// by the single write port of the screen store and the sequencer that drives
// it. A printable character, newline or backspace passes a scroll check and a
// cell read waits for the store; a bell, null, keyboard backspace held at the
// mark or out-of-range read goes straight to the result; a tab steps through
// TAB_STEP cells; a request that scrolls adds one sweep over the whole screen;
// a clear is one sweep over the whole screen. The result sits in an output
// register, so the next request is taken while the previous result waits on
// rsp_port.
module text_terminal_char_engine_unit #(
   parameter int COLUMNS  = 80,
   parameter int LAST_ROW = 24,
   parameter int TAB_STEP = 4
) (
   input  logic        clock,
   input  logic        reset,
   tte_req_if.sink     req_port,
   tte_rsp_if.source   rsp_port,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int CELLS  = (LAST_ROW + 1) * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);

   logic [7:0]               text_color_ff;
   tte_pkg::tte_request_type req;
   tte_pkg::tte_result_type  res;
   tte_pkg::tte_result_type  out_ff;
   logic                     out_valid_ff;
   logic                     res_valid;
   logic                     res_take;
   tte_pkg::tte_wr_ctl_type  wr_ctl;
   logic [ADDR_W-1:0]        wr_addr;
   logic [15:0]              wr_data;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [15:0]              rd_data;

   assign req.req_type  = tte_pkg::tte_req_kind_type'(req_port.req_type);
   assign req.char_code = req_port.char_code;
   assign req.cell_addr = req_port.cell_addr;

   // result word moves on when the output register is empty or being drained
   assign res_take = !out_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         out_ff <= res;
      end
      if (reset) begin
         text_color_ff <= tte_pkg::COLOR_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            text_color_ff <= csr_wdata;
         end
         if (res_valid && res_take) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.cursor_index = out_ff.cursor_index;
   assign rsp_port.bell         = out_ff.bell;
   assign rsp_port.scrolled     = out_ff.scrolled;
   assign rsp_port.read_data    = out_ff.read_data;

   tte_ctrl #(
      .COLUMNS  (COLUMNS),
      .LAST_ROW (LAST_ROW),
      .TAB_STEP (TAB_STEP)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_port.valid),
      .req_ready  (req_port.ready),
      .req        (req),
      .text_color (text_color_ff),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res),
      .wr_ctl     (wr_ctl),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   tte_screen_mem #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_screen (
      .clock   (clock),
      .wr_ctl  (wr_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

/* tb/tb_text_terminal_char_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_terminal_char_engine_unit
// Self-checking bench for the text terminal engine. A shadow copy of the
// screen, cursor and protect marks predicts the result word of each request
// accepted on the request channel. Every response word is checked field by
// field against the oldest prediction. Stimulus is a short directed pass
// (reset contents, editing keys, clear and colour), a long output stall, and
// then random traffic built from well-formed text sequences and some noise,
// under several colour settings.
// ----------------------------------------------------------------------------
module tb_text_terminal_char_engine_unit;

   localparam int COLUMNS       = 80;
   localparam int LAST_ROW      = 24;
   localparam int TAB_STEP      = 4;
   localparam int CELL_COUNT    = (LAST_ROW + 1) * COLUMNS;
   localparam int CLK_PERIOD    = 10;
   localparam int IDLE_PCT      = 19;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 300;
   localparam int PHASE_COUNT   = 6;
   localparam int CYCLE_LIMIT   = 20000000;
   localparam int REPORT_LIMIT  = 10;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   tte_req_if req_bus ();
   tte_rsp_if rsp_bus ();

   text_terminal_char_engine_unit #(
      .COLUMNS  (COLUMNS),
      .LAST_ROW (LAST_ROW),
      .TAB_STEP (TAB_STEP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow terminal
   logic [15:0]    shadow_cells [CELL_COUNT];
   int             caret_row;
   int             caret_col;
   int             guard_col [LAST_ROW + 1];
   logic [7:0]     ink_attr;

   tte_pkg::tte_result_type terminal_reports [$];
   int             mismatch_count = 0;
   int             words_sent = 0;
   bit             no_idle = 1'b0;
   bit             hold_request = 1'b0;

   function automatic void paint_cell(int c, int r, logic [7:0] ch);
      if (r <= LAST_ROW && c < COLUMNS)
         shadow_cells[r * COLUMNS + c] = {ink_attr, ch};
   endfunction

   function automatic void raise_guard(int r, int amount);
      if (r <= LAST_ROW)
         guard_col[r] = (guard_col[r] + amount > COLUMNS) ? COLUMNS : guard_col[r] + amount;
   endfunction

   function automatic bit roll_screen();
      int i;
      if (caret_row <= LAST_ROW)
         return 1'b0;
      for (i = 0; i < LAST_ROW * COLUMNS; i++)
         shadow_cells[i] = shadow_cells[i + COLUMNS];
      for (i = 0; i < LAST_ROW; i++)
         guard_col[i] = guard_col[i + 1];
      guard_col[LAST_ROW] = 0;
      for (i = 0; i < COLUMNS; i++)
         shadow_cells[LAST_ROW * COLUMNS + i] = {ink_attr, tte_pkg::CH_SPACE};
      caret_row = LAST_ROW;
      return 1'b1;
   endfunction

   function automatic void place_glyph(logic [7:0] ch, bit prot, inout bit rang,
                                       inout bit rolled);
      int i;
      case (ch)
         tte_pkg::CH_NEWLINE: begin
            caret_col = 0;
            caret_row++;
         end
         tte_pkg::CH_BACKSPACE: begin
            if (caret_col > 0) begin
               caret_col--;
               paint_cell(caret_col, caret_row, tte_pkg::CH_SPACE);
            end else if (caret_row > 0) begin
               caret_row--;
               caret_col = (guard_col[caret_row] > COLUMNS - 1) ? COLUMNS - 1
                                                                 : guard_col[caret_row];
            end
         end
         tte_pkg::CH_BELL: rang = 1'b1;
         tte_pkg::CH_TAB: begin
            if (caret_col + TAB_STEP >= COLUMNS) begin
               caret_col = 0;
               caret_row++;
            end
            for (i = 0; i < TAB_STEP; i++)
               paint_cell(caret_col + i, caret_row, tte_pkg::CH_SPACE);
            caret_col += TAB_STEP;
            if (caret_col > COLUMNS - 1)
               caret_col = COLUMNS - 1;
            if (prot)
               raise_guard(caret_row, TAB_STEP);
         end
         tte_pkg::CH_NULL: ;
         default: begin
            paint_cell(caret_col, caret_row, ch);
            caret_col++;
            if (caret_col >= COLUMNS) begin
               caret_col = 0;
               caret_row++;
            end
            if (prot)
               raise_guard(caret_row, 1);
         end
      endcase
      if (roll_screen())
         rolled = 1'b1;
   endfunction

   function automatic tte_pkg::tte_result_type advance_terminal(
      tte_pkg::tte_request_type rq);
      tte_pkg::tte_result_type res;
      bit             rang;
      bit             rolled;
      logic [15:0]    cell_word;
      int             i;
      rang      = 1'b0;
      rolled    = 1'b0;
      cell_word = '0;
      case (rq.req_type)
         tte_pkg::REQ_PROT: place_glyph(rq.char_code, 1'b1, rang, rolled);
         tte_pkg::REQ_KEY: begin
            if (rq.char_code != tte_pkg::CH_BACKSPACE)
               place_glyph(rq.char_code, 1'b0, rang, rolled);
            else if (caret_row <= LAST_ROW && caret_col > guard_col[caret_row])
               place_glyph(tte_pkg::CH_BACKSPACE, 1'b0, rang, rolled);
         end
         tte_pkg::REQ_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++)
               shadow_cells[i] = {ink_attr, tte_pkg::CH_SPACE};
            for (i = 0; i <= LAST_ROW; i++)
               guard_col[i] = 0;
            caret_row = 0;
            caret_col = 0;
         end
         default: begin
            if (rq.cell_addr < CELL_COUNT)
               cell_word = shadow_cells[rq.cell_addr];
         end
      endcase
      res.cursor_index = 11'(caret_row * COLUMNS + caret_col);
      res.bell         = rang;
      res.scrolled     = rolled;
      res.read_data    = cell_word;
      return res;
   endfunction

   function automatic logic [7:0] pick_printable();
      logic [7:0] ch;
      do
         ch = 8'($urandom_range(255));
      while (ch == tte_pkg::CH_NULL || ch == tte_pkg::CH_BELL ||
             ch == tte_pkg::CH_BACKSPACE || ch == tte_pkg::CH_TAB ||
             ch == tte_pkg::CH_NEWLINE);
      return ch;
   endfunction

   function automatic tte_pkg::tte_req_kind_type pick_text_kind();
      return $urandom_range(1) ? tte_pkg::REQ_KEY : tte_pkg::REQ_PROT;
   endfunction

   function automatic logic [10:0] addr_near_caret();
      return 11'(caret_row * COLUMNS + $urandom_range(COLUMNS - 1));
   endfunction

   // one request word; returns once the engine has taken it
   task automatic issue_request(tte_pkg::tte_req_kind_type kind, logic [7:0] ch,
                                logic [10:0] addr);
      tte_pkg::tte_request_type rq;
      int              gap;
      rq.req_type  = kind;
      rq.char_code = ch;
      rq.cell_addr = addr;
      gap = 0;
      if (!no_idle)
         while ($urandom_range(99) < IDLE_PCT && gap < 6)
            gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.char_code <= ch;
      req_bus.cell_addr <= addr;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      terminal_reports.push_back(advance_terminal(rq));
      words_sent++;
   endtask

   task automatic settle_engine();
      req_bus.valid <= 1'b0;
      while (terminal_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colour(logic [7:0] attr);
      csr_we    <= 1'b1;
      csr_wdata <= attr;
      @(posedge clock);
      csr_we    <= 1'b0;
      ink_attr = attr;
   endtask

   // ------------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------------
   task automatic test_reset_screen();
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, 11'd0);
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, 11'(CELL_COUNT - 1));
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, 11'(CELL_COUNT));
      issue_request(tte_pkg::REQ_READ, 8'hFF, 11'h7FF);
   endtask

   task automatic test_editing_keys();
      issue_request(tte_pkg::REQ_PROT, 8'h41, 11'd0);
      issue_request(tte_pkg::REQ_KEY, 8'hFF, 11'h7FF);
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BACKSPACE, 11'd0);   // above the mark: allowed
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BACKSPACE, 11'd0);   // at the mark: ignored
      issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_BACKSPACE, 11'd0);  // protected may cross
      issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_BACKSPACE, 11'd0);  // top-left: nothing
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BELL, 11'd0);
      issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_NULL, 11'd0);
      issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_TAB, 11'd0);
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_NEWLINE, 11'd0);
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BACKSPACE, 11'd0);   // column 0, mark 0
      issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_BACKSPACE, 11'd0);  // up to row's mark
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, 11'd0);
   endtask

   task automatic test_clear_colour();
      settle_engine();
      write_colour(8'hA5);
      issue_request(tte_pkg::REQ_PROT, 8'h5A, 11'd0);
      issue_request(tte_pkg::REQ_CLEAR, 8'h80, 11'h400);
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, 11'd0);
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, 11'(CELL_COUNT - 1));
   endtask

   // receiver stalls long enough for the output register and input to back up
   task automatic test_output_stall();
      settle_engine();
      hold_request = 1'b1;
      repeat (16)
         issue_request(tte_pkg::REQ_KEY, pick_printable(), 11'($urandom_range(2047)));
      settle_engine();
   endtask

   // ------------------------------------------------------------------------
   // random traffic
   // ------------------------------------------------------------------------
   task automatic text_burst();
      int n;
      int pick;
      n = $urandom_range(5, 30);
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 50)
            issue_request(pick_text_kind(), pick_printable(), 11'($urandom_range(2047)));
         else if (pick < 60)
            issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BACKSPACE,
                          11'($urandom_range(2047)));
         else if (pick < 65)
            issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_BACKSPACE,
                          11'($urandom_range(2047)));
         else if (pick < 72)
            issue_request(pick_text_kind(), tte_pkg::CH_TAB, 11'($urandom_range(2047)));
         else if (pick < 76)
            issue_request(pick_text_kind(), tte_pkg::CH_NEWLINE, 11'($urandom_range(2047)));
         else if (pick < 79)
            issue_request(pick_text_kind(), tte_pkg::CH_BELL, 11'($urandom_range(2047)));
         else if (pick < 81)
            issue_request(pick_text_kind(), tte_pkg::CH_NULL, 11'($urandom_range(2047)));
         else if (pick < 92)
            issue_request(tte_pkg::REQ_READ, 8'($urandom_range(255)), addr_near_caret());
         else
            issue_request(tte_pkg::REQ_READ, 8'($urandom_range(255)),
                          11'($urandom_range(2047)));
      end
   endtask

   task automatic noise_burst();
      tte_pkg::tte_req_kind_type kind;
      repeat ($urandom_range(4, 10)) begin
         kind = tte_pkg::tte_req_kind_type'($urandom_range(3));
         // clears are slow, keep them scarce
         if (kind == tte_pkg::REQ_CLEAR && $urandom_range(9) != 0)
            kind = tte_pkg::REQ_READ;
         issue_request(kind, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      end
   endtask

   // runs the cursor past the line end, by characters or by tabs
   task automatic line_runout();
      int n;
      if ($urandom_range(1)) begin
         n = COLUMNS - caret_col + $urandom_range(2);
         repeat (n)
            issue_request(pick_text_kind(), pick_printable(), 11'($urandom_range(2047)));
      end else begin
         n = (COLUMNS - caret_col) / TAB_STEP + 2;
         repeat (n)
            issue_request(pick_text_kind(), tte_pkg::CH_TAB, 11'($urandom_range(2047)));
      end
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, addr_near_caret());
   endtask

   task automatic run_to_bottom();
      int n;
      n = LAST_ROW - caret_row + 1;
      repeat (n)
         issue_request(pick_text_kind(), tte_pkg::CH_NEWLINE, 11'($urandom_range(2047)));
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL,
                    11'(LAST_ROW * COLUMNS + $urandom_range(COLUMNS - 1)));
   endtask

   // protected char + protected backspace pairs drive the row's mark to saturation
   task automatic guard_pump();
      int n;
      if (caret_col != 0)
         issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_NEWLINE, 11'($urandom_range(2047)));
      n = $urandom_range(82, 90);
      repeat (n) begin
         issue_request(tte_pkg::REQ_PROT, pick_printable(), 11'($urandom_range(2047)));
         issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_BACKSPACE,
                       11'($urandom_range(2047)));
      end
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BACKSPACE, 11'($urandom_range(2047)));
      issue_request(tte_pkg::REQ_PROT, pick_printable(), 11'($urandom_range(2047)));
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BACKSPACE, 11'($urandom_range(2047)));
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_NEWLINE, 11'($urandom_range(2047)));
      issue_request(tte_pkg::REQ_KEY, tte_pkg::CH_BACKSPACE, 11'($urandom_range(2047)));
      issue_request(tte_pkg::REQ_PROT, tte_pkg::CH_BACKSPACE, 11'($urandom_range(2047)));
      issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, addr_near_caret());
   endtask

   task automatic clear_and_probe();
      issue_request(tte_pkg::REQ_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      repeat (3)
         issue_request(tte_pkg::REQ_READ, tte_pkg::CH_NULL, 11'($urandom_range(2047)));
   endtask

   task automatic test_random_traffic();
      int         phase;
      int         start;
      int         pick;
      logic [7:0] attr;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_engine();
         case (phase)
            0:       attr = 8'h00;
            1:       attr = 8'hFF;
            3:       attr = tte_pkg::COLOR_RESET;
            default: attr = 8'($urandom_range(255));
         endcase
         write_colour(attr);
         no_idle = (phase == 2);
         start = words_sent;
         while (words_sent - start < PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 60)
               text_burst();
            else if (pick < 70)
               noise_burst();
            else if (pick < 85)
               line_runout();
            else if (pick < 93)
               run_to_bottom();
            else if (pick < 96)
               guard_pump();
            else if (pick < 97)
               clear_and_probe();
            else
               text_burst();
         end
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin
      int count;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            for (count = 1; count < HOLD_CYCLES; count++)
               @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : check_results
      tte_pkg::tte_result_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (terminal_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: response word with none outstanding: cur=%0d", $realtime,
                        rsp_bus.cursor_index);
         end else begin
            want = terminal_reports.pop_front();
            if (rsp_bus.cursor_index !== want.cursor_index || rsp_bus.bell !== want.bell ||
                rsp_bus.scrolled !== want.scrolled || rsp_bus.read_data !== want.read_data)
            begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: mismatch exp cur=%0d bell=%0b scr=%0b rd=%h, ",
                            "got cur=%0d bell=%0b scr=%0b rd=%h"},
                           $realtime, want.cursor_index, want.bell, want.scrolled,
                           want.read_data, rsp_bus.cursor_index, rsp_bus.bell,
                           rsp_bus.scrolled, rsp_bus.read_data);
            end
         end
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int i;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = tte_pkg::REQ_READ;
      req_bus.char_code = tte_pkg::CH_NULL;
      req_bus.cell_addr = '0;
      for (i = 0; i < CELL_COUNT; i++)
         shadow_cells[i] = tte_pkg::CELL_RESET;
      for (i = 0; i <= LAST_ROW; i++)
         guard_col[i] = 0;
      caret_row = 0;
      caret_col = 0;
      ink_attr  = tte_pkg::COLOR_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_screen();
      test_editing_keys();
      test_clear_colour();
      test_output_stall();
      test_random_traffic();

      settle_engine();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
